### hw/rtl/vhp_pkg.sv
// Package for the packet header parser: header length, result layout and
// the function that decodes the stored header bytes into a result item.
// Used by vhp_cell and vita49_header_parser_top.
`default_nettype none

package vhp_pkg;

    localparam int HEADER_LEN  = 28;
    localparam int COUNT_W     = $clog2(HEADER_LEN + 1);
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 224;

    typedef logic [HEADER_LEN-1:0][7:0] header_bytes_t;

    // First declared member lands in the highest bits, so header_ok is bit 0.
    typedef struct packed {
        logic        pad;
        logic [63:0] fraction_stamp;
        logic [31:0] seconds_stamp;
        logic [63:0] class_ident;
        logic [31:0] stream_ident;
        logic [15:0] size_words;
        logic [3:0]  sequence_count;
        logic [1:0]  fraction_ts_kind;
        logic [1:0]  integer_ts_kind;
        logic        trailer_present;
        logic        class_present;
        logic [3:0]  hdr_type;
        logic        header_ok;
    } header_result_t;

    function automatic logic [31:0] be_word(input header_bytes_t hb, input int unsigned idx);
        be_word = {hb[4*idx], hb[4*idx+1], hb[4*idx+2], hb[4*idx+3]};
    endfunction

    function automatic header_result_t decode_header(input header_bytes_t hb, input logic ok);
        header_result_t r;
        logic [31:0]    w0;
        r  = '0;
        w0 = be_word(hb, 0);
        if (ok) begin
            r.header_ok        = 1'b1;
            r.hdr_type         = w0[31:28];
            r.class_present    = w0[27];
            r.trailer_present  = w0[26];
            r.integer_ts_kind  = w0[23:22];
            r.fraction_ts_kind = w0[21:20];
            r.sequence_count   = w0[19:16];
            r.size_words       = w0[15:0];
            r.stream_ident     = be_word(hb, 1);
            r.class_ident      = w0[27] ? {be_word(hb, 2), be_word(hb, 3)} : 64'd0;
            r.seconds_stamp    = be_word(hb, 4);
            r.fraction_stamp   = {be_word(hb, 5), be_word(hb, 6)};
        end
        decode_header = r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/vhp_cell.sv
// One byte cell of the header shift line. It takes its neighbor's byte when
// the line shifts and shows its next value for the decoder. Uses vhp_pkg.
`default_nettype none

module vhp_cell (
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire logic [7:0] d_in,
    output logic      [7:0] q,
    output logic      [7:0] q_next
);
    import vhp_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = shift_en ? d_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign q      = byte_reg;
    assign q_next = byte_next;

endmodule

`default_nettype wire

### hw/rtl/vita49_header_parser_top.sv
// Packet header parser top level: a row of byte cells, a byte counter and
// an output register. Depends on vhp_pkg and vhp_cell.
// The result item appears in the cycle after the last byte is taken.
// Throughput: one byte per cycle; input stalls only while a result waits
// in the output register and m_tready is low.
// Reset clears the byte counter and the output valid flag; cell bytes are not reset.
`default_nettype none

module vita49_header_parser_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vhp_pkg::IN_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic                           s_tlast,  // last_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // From bit 0 up: header_ok, hdr_type, class_present, trailer_present,
    // integer_ts_kind, fraction_ts_kind, sequence_count, size_words,
    // stream_ident, class_ident, seconds_stamp, fraction_stamp, one zero bit.
    output logic [vhp_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import vhp_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    header_result_t     out_data_reg;
    logic               in_accept;
    logic               shift_en;
    logic               header_ok;
    header_bytes_t      cell_q;
    header_bytes_t      cell_next;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign shift_en  = in_accept && (count_reg < COUNT_W'(HEADER_LEN));

    // Bytes enter at the tail and move toward cell 0, so after a full header
    // cell k holds byte k of the packet.
    genvar gi;
    generate
        for (gi = 0; gi < HEADER_LEN; gi++) begin : g_cell
            logic [7:0] d_in;
            if (gi == HEADER_LEN - 1) begin : g_tail
                assign d_in = s_tdata[7:0];
            end else begin : g_body
                assign d_in = cell_q[gi+1];
            end
            vhp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (d_in),
                .q        (cell_q[gi]),
                .q_next   (cell_next[gi])
            );
        end
    endgenerate

    // The header is complete once this item brings the count to the full length.
    assign header_ok = (count_reg >= COUNT_W'(HEADER_LEN - 1));

    always_comb begin
        count_next = count_reg;
        if (in_accept) begin
            if (s_tlast) begin
                count_next = '0;
            end else if (count_reg < COUNT_W'(HEADER_LEN)) begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (in_accept && s_tlast) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && s_tlast) begin
            out_data_reg <= decode_header(cell_next, header_ok);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("last byte taken without a result item");

    a_short_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("short packet result carries nonzero fields");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(HEADER_LEN))
        else $error("byte count beyond header length");

    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (count_reg == '0))
        else $error("byte count not cleared after last byte");

endmodule

`default_nettype wire
